// ----- src/iwn_pkg.sv -----
package iwn_pkg;

    // normalized value width and the fixed payload widths around it
    localparam int VAL_W      = 20;
    localparam int PROD_W     = 2 * VAL_W;
    localparam int DIV_STEPS  = VAL_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);
    localparam int OUT_DATA_W = ((VAL_W + 7) / 8) * 8;

    localparam logic [VAL_W-1:0] TARGET_RESET = VAL_W'(1000);

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_CHECK,
        ST_SC_RD,
        ST_SC_MUL,
        ST_SC_DIV,
        ST_SC_WR,
        ST_FIX,
        ST_SR_RD,
        ST_SR_CHK,
        ST_EM_RD,
        ST_EM_LD
    } state_t;

    typedef enum logic [1:0] {
        FIX_NONE,
        FIX_EXCESS,
        FIX_DEFICIT
    } fix_t;

    typedef struct packed {
        logic load;
        logic run_start;
        logic rd_en;
        logic mul_en;
        logic div_step;
        logic sc_wr;
        logic fix_en;
        logic idx_clr;
        logic idx_inc;
        logic found_set;
        logic em_load;
        logic run_end;
    } cmd_t;

    typedef struct packed {
        logic total_zero;
        logic idx_last;
        logic div_last;
        logic over;
        logic hit;
        logic out_free;
    } status_t;

endpackage

// ----- src/iwn_ctrl.sv -----
module iwn_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    input  logic            s_tlast,
    output logic            s_tready,
    input  iwn_pkg::status_t status,
    output iwn_pkg::cmd_t    cmd
);
    import iwn_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (s_tvalid && s_tlast)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = status.total_zero ? ST_EM_RD : ST_SC_RD;
            end
            ST_SC_RD:  state_next = ST_SC_MUL;
            ST_SC_MUL: state_next = ST_SC_DIV;
            ST_SC_DIV:
            begin
                if (status.div_last)
                begin
                    state_next = ST_SC_WR;
                end
            end
            ST_SC_WR:
            begin
                state_next = status.idx_last ? ST_FIX : ST_SC_RD;
            end
            ST_FIX:
            begin
                state_next = status.over ? ST_SR_RD : ST_EM_RD;
            end
            ST_SR_RD:  state_next = ST_SR_CHK;
            ST_SR_CHK:
            begin
                if (status.hit || status.idx_last)
                begin
                    state_next = ST_EM_RD;
                end
                else
                begin
                    state_next = ST_SR_RD;
                end
            end
            ST_EM_RD:  state_next = ST_EM_LD;
            ST_EM_LD:
            begin
                if (status.out_free)
                begin
                    state_next = status.idx_last ? ST_LOAD : ST_EM_RD;
                end
            end
            default:   state_next = ST_LOAD;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_CHECK:
            begin
                cmd.run_start = 1'b1;
            end
            ST_SC_RD:
            begin
                cmd.rd_en = 1'b1;
            end
            ST_SC_MUL:
            begin
                cmd.mul_en = 1'b1;
            end
            ST_SC_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            ST_SC_WR:
            begin
                cmd.sc_wr   = 1'b1;
                cmd.idx_inc = 1'b1;
            end
            ST_FIX:
            begin
                cmd.fix_en  = 1'b1;
                cmd.idx_clr = 1'b1;
            end
            ST_SR_RD:
            begin
                cmd.rd_en = 1'b1;
            end
            ST_SR_CHK:
            begin
                if (status.hit)
                begin
                    cmd.found_set = 1'b1;
                    cmd.idx_clr   = 1'b1;
                end
                else if (status.idx_last)
                begin
                    cmd.idx_clr = 1'b1;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_EM_RD:
            begin
                cmd.rd_en = 1'b1;
            end
            ST_EM_LD:
            begin
                if (status.out_free)
                begin
                    cmd.em_load = 1'b1;
                    if (status.idx_last)
                    begin
                        cmd.run_end = 1'b1;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                    end
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ----- src/iwn_datapath.sv -----
module iwn_datapath #(
    parameter int MAX_LEN     = 64,
    parameter int WEIGHT_BITS = 16
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [iwn_pkg::VAL_W-1:0]        cfg_wdata,
    input  logic [WEIGHT_BITS-1:0]           in_weight,
    input  iwn_pkg::cmd_t                    cmd,
    input  logic                             m_tready,
    output logic                             m_tvalid,
    output logic [iwn_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                             m_tuser,
    output logic                             m_tlast,
    output iwn_pkg::status_t                 status
);
    import iwn_pkg::*;

    localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam int TOT_W = WEIGHT_BITS + CNT_W;
    localparam int SC_W  = VAL_W + CNT_W;

    logic [VAL_W-1:0]  mem [MAX_LEN];
    logic [VAL_W-1:0]  rd_data_reg;

    logic [VAL_W-1:0]  target_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [TOT_W-1:0]  total_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [SC_W-1:0]   scaled_reg;
    logic [SC_W-1:0]   corr_reg;
    fix_t              fix_reg;
    logic              found_reg;
    logic [IDX_W-1:0]  found_idx_reg;
    logic              err_reg;

    logic [TOT_W-1:0]  rem_reg;
    logic [VAL_W-1:0]  quo_reg;
    logic [STEP_W-1:0] step_reg;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [VAL_W-1:0]  mem_wdata;
    logic              room;
    logic [PROD_W-1:0] product;
    logic [TOT_W:0]    trial;
    logic              trial_ge;
    logic [VAL_W-1:0]  scaled_val;
    logic [VAL_W-1:0]  emit_val;

    assign room    = (count_reg < CNT_W'(MAX_LEN));
    assign product = PROD_W'(rd_data_reg) * PROD_W'(target_reg);

    // restoring division, one quotient bit per step
    assign trial    = {rem_reg, quo_reg[VAL_W-1]};
    assign trial_ge = (trial >= {1'b0, total_reg});

    // a floor of zero is raised to one
    assign scaled_val = (quo_reg == '0) ? VAL_W'(1) : quo_reg;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = scaled_val;
        if (cmd.load && room)
        begin
            mem_we    = 1'b1;
            mem_waddr = count_reg[IDX_W-1:0];
            mem_wdata = VAL_W'(in_weight);
        end
        else if (cmd.sc_wr)
        begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[idx_reg];
        end
    end

    // apply the correction on the way out
    always_comb
    begin
        emit_val = rd_data_reg;
        if (!err_reg)
        begin
            if (fix_reg == FIX_EXCESS && found_reg && idx_reg == found_idx_reg)
            begin
                emit_val = VAL_W'(SC_W'(rd_data_reg) - corr_reg);
            end
            else if (fix_reg == FIX_DEFICIT && SC_W'(idx_reg) < corr_reg)
            begin
                emit_val = rd_data_reg + VAL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= TARGET_RESET;
            count_reg  <= '0;
            total_reg  <= '0;
            idx_reg    <= '0;
            scaled_reg <= '0;
            fix_reg    <= FIX_NONE;
            found_reg  <= 1'b0;
            err_reg    <= 1'b0;
            step_reg   <= '0;
            m_tvalid   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                target_reg <= cfg_wdata;
            end

            if (cmd.run_end)
            begin
                count_reg <= '0;
                total_reg <= '0;
            end
            else if (cmd.load && room)
            begin
                count_reg <= count_reg + CNT_W'(1);
                total_reg <= total_reg + TOT_W'(in_weight);
            end

            if (cmd.run_start || cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end

            if (cmd.run_start)
            begin
                scaled_reg <= '0;
                fix_reg    <= FIX_NONE;
                found_reg  <= 1'b0;
                err_reg    <= (total_reg == '0);
            end
            else if (cmd.sc_wr)
            begin
                scaled_reg <= scaled_reg + SC_W'(scaled_val);
            end

            if (cmd.fix_en)
            begin
                if (status.over)
                begin
                    fix_reg <= FIX_EXCESS;
                end
                else if (scaled_reg < SC_W'(target_reg))
                begin
                    fix_reg <= FIX_DEFICIT;
                end
                else
                begin
                    fix_reg <= FIX_NONE;
                end
            end

            if (cmd.found_set)
            begin
                found_reg <= 1'b1;
            end

            if (cmd.mul_en)
            begin
                step_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                step_reg <= step_reg + STEP_W'(1);
            end

            if (cmd.em_load)
            begin
                m_tvalid <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.fix_en)
        begin
            if (status.over)
            begin
                corr_reg <= scaled_reg - SC_W'(target_reg);
            end
            else
            begin
                corr_reg <= SC_W'(target_reg) - scaled_reg;
            end
        end

        if (cmd.found_set)
        begin
            found_idx_reg <= idx_reg;
        end

        if (cmd.mul_en)
        begin
            // the quotient fits VAL_W bits, so the upper half is already below total
            rem_reg <= TOT_W'(product >> VAL_W);
            quo_reg <= product[VAL_W-1:0];
        end
        else if (cmd.div_step)
        begin
            if (trial_ge)
            begin
                rem_reg <= TOT_W'(trial - {1'b0, total_reg});
            end
            else
            begin
                rem_reg <= trial[TOT_W-1:0];
            end
            quo_reg <= {quo_reg[VAL_W-2:0], trial_ge};
        end

        if (cmd.em_load)
        begin
            m_tdata <= OUT_DATA_W'(emit_val);
            m_tuser <= err_reg;
            m_tlast <= status.idx_last;
        end
    end

    assign status.total_zero = (total_reg == '0);
    assign status.idx_last   = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign status.div_last   = (step_reg == STEP_W'(DIV_STEPS - 1));
    assign status.over       = (scaled_reg > SC_W'(target_reg));
    assign status.hit        = ((SC_W + 1)'(rd_data_reg) > ((SC_W + 1)'(corr_reg) + (SC_W + 1)'(1)));
    assign status.out_free   = !m_tvalid || m_tready;

endmodule

// ----- src/integer_weight_normalize_top.sv -----
// Channel   Direction  Handshake                  Contents
// s_*       in         s_tvalid / s_tready        s_tdata: weight; s_tlast: is_last
// m_*       out        m_tvalid / m_tready        m_tdata: scaled_weight; m_tuser: error;
//                                                 m_tlast: last_out
// cfg_*     in         cfg_we (no wait)           cfg_wdata: target_sum
//
// One weight loads per cycle. After the last weight come a check state, then per element scaling
// (read, 20x20 multiply, 20 steps on the shared bit-serial divider, write-back), a fix state, a
// search for the excess element when over target, and per element a read and an emit.
// rst_n clears control state and sets target_sum to 1000; the element memory is not cleared.
// s_tready is low from the last weight until the run's final result sits in the output
// register; m_tready low holds the output register and pauses emission.
module integer_weight_normalize_top #(
    parameter int MAX_LEN     = 64,
    parameter int WEIGHT_BITS = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [iwn_pkg::VAL_W-1:0]           cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((WEIGHT_BITS+7)/8)*8-1:0]    s_tdata,   // weight
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [iwn_pkg::OUT_DATA_W-1:0]      m_tdata,   // scaled_weight
    output logic                                m_tuser,   // error
    output logic                                m_tlast
);
    import iwn_pkg::*;

    cmd_t    cmd;
    status_t status;

    iwn_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    iwn_datapath #(
        .MAX_LEN     (MAX_LEN),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_weight (s_tdata[WEIGHT_BITS-1:0]),
        .cmd       (cmd),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .status    (status)
    );

    // never overwrite a result that is still waiting
    a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.em_load |-> (!m_tvalid || m_tready))
        else $error("result loaded over a pending one");

    a_valid_source : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(cmd.em_load))
        else $error("output valid without a load");

    a_div_before_wr : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sc_wr |-> $past(cmd.div_step))
        else $error("write-back without a finished division");

    a_no_load_busy : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (!cmd.rd_en && !cmd.sc_wr && !cmd.em_load))
        else $error("weight loaded while the run is busy");

endmodule
